[sv/bal_pkg.sv]
// ----------------------------------------------------------------------------
// bal_pkg - shared types and constants for the bounded array list
// Sizes, request and status codes, beat structs and per-cell control.
// ----------------------------------------------------------------------------
package bal_pkg;

  // list geometry
  localparam int DEPTH = 16;
  localparam int WIDTH = 32;

  // fixed field widths of the beats
  localparam int VAL_W   = 32;
  localparam int POS_W   = 4;
  localparam int KIND_W  = 3;
  localparam int COUNT_W = 5;

  // derived widths
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = CNT_W + POS_W;

  typedef logic [WIDTH-1:0] elem_t;

  // request kinds
  typedef enum logic [KIND_W-1:0] {
    K_APPEND = 3'd0,
    K_INSERT = 3'd1,
    K_DELETE = 3'd2,
    K_POP    = 3'd3,
    K_READ   = 3'd4
  } kind_t;

  // result status
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [VAL_W-1:0]  value_in;
    logic [POS_W-1:0]  position;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0]   value_out;
    logic [1:0]         status;
    logic [COUNT_W-1:0] count_out;
    logic               is_empty;
    logic               is_full;
  } out_t;

  // what one cell does this cycle
  typedef struct packed {
    logic shift_up;    // take neighbour below
    logic shift_down;  // take neighbour above
    logic load;        // take the new element
  } cell_ctl_t;

endpackage

[sv/bal_cell.sv]
// ----------------------------------------------------------------------------
// bal_cell - one storage slot of the list
// Holds one element; shifts from either neighbour or loads a new element.
// ----------------------------------------------------------------------------
module bal_cell (
  input  logic              clk,
  input  bal_pkg::cell_ctl_t ctl,
  input  bal_pkg::elem_t    prev_d,
  input  bal_pkg::elem_t    next_d,
  input  bal_pkg::elem_t    load_d,
  output bal_pkg::elem_t    q
);

  bal_pkg::elem_t q_r;
  bal_pkg::elem_t q_nxt;

  // next value select
  always_comb begin
    q_nxt = q_r;
    if (ctl.shift_up) begin
      q_nxt = prev_d;
    end else if (ctl.shift_down) begin
      q_nxt = next_d;
    end else if (ctl.load) begin
      q_nxt = load_d;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

[sv/bounded_array_list.sv]
// ----------------------------------------------------------------------------
// bounded_array_list - ordered list of DEPTH entries with insert and delete
// A row of cells shifts in parallel, so every request completes at once.
// ----------------------------------------------------------------------------
// Result: registered; the result beat appears in the cycle after start is taken.
// Throughput: one request per cycle while busy is low; the cells that move
//   shift together in that cycle, and reads go through one DEPTH-way select.
// Reset: synchronous; the count clears, busy is high while reset is held,
//   cell contents are left as they are.
module bounded_array_list (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  bal_pkg::in_t  in_data,
  output logic          out_valid,
  output bal_pkg::out_t out_data
);

  logic [bal_pkg::CNT_W-1:0] count_r;
  logic [bal_pkg::CNT_W-1:0] count_nxt;
  logic                      busy_r;
  logic                      out_valid_r;
  bal_pkg::out_t             out_data_r;
  bal_pkg::out_t             out_data_nxt;

  logic                      accept;
  logic                      is_full;
  logic                      is_empty;
  logic                      pos_ok;
  logic [bal_pkg::CMP_W-1:0] pos_ext;
  logic [bal_pkg::CMP_W-1:0] cnt_ext;
  logic                      do_append;
  logic                      do_insert;
  logic                      do_delete;
  logic                      rd_en;
  logic [bal_pkg::IDX_W-1:0] rd_idx;
  bal_pkg::status_t          status;
  bal_pkg::elem_t            new_elem;
  bal_pkg::elem_t            cell_q [bal_pkg::DEPTH];

  assign accept   = start && !busy_r;
  assign is_full  = (count_r == bal_pkg::CNT_W'(bal_pkg::DEPTH));
  assign is_empty = (count_r == '0);
  assign pos_ext  = bal_pkg::CMP_W'(in_data.position);
  assign cnt_ext  = bal_pkg::CMP_W'(count_r);
  assign pos_ok   = (pos_ext < cnt_ext);
  assign new_elem = bal_pkg::WIDTH'(in_data.value_in);

  // request decode
  always_comb begin
    do_append = 1'b0;
    do_insert = 1'b0;
    do_delete = 1'b0;
    rd_en     = 1'b0;
    rd_idx    = '0;
    status    = bal_pkg::ST_OK;
    count_nxt = count_r;
    case (in_data.kind)
      bal_pkg::K_APPEND: begin
        if (is_full) begin
          status = bal_pkg::ST_FULL;
        end else begin
          do_append = accept;
          count_nxt = count_r + bal_pkg::CNT_W'(1);
        end
      end
      bal_pkg::K_INSERT: begin
        if (is_full) begin
          status = bal_pkg::ST_FULL;
        end else begin
          do_insert = accept;
          count_nxt = count_r + bal_pkg::CNT_W'(1);
        end
      end
      bal_pkg::K_DELETE: begin
        if (is_empty) begin
          status = bal_pkg::ST_EMPTY;
        end else if (!pos_ok) begin
          status = bal_pkg::ST_BADPOS;
        end else begin
          do_delete = accept;
          count_nxt = count_r - bal_pkg::CNT_W'(1);
        end
      end
      bal_pkg::K_POP: begin
        if (is_empty) begin
          status = bal_pkg::ST_EMPTY;
        end else begin
          rd_en     = 1'b1;
          rd_idx    = bal_pkg::IDX_W'(count_r - bal_pkg::CNT_W'(1));
          count_nxt = count_r - bal_pkg::CNT_W'(1);
        end
      end
      bal_pkg::K_READ: begin
        if (is_empty) begin
          status = bal_pkg::ST_EMPTY;
        end else if (!pos_ok) begin
          status = bal_pkg::ST_BADPOS;
        end else begin
          rd_en  = 1'b1;
          rd_idx = bal_pkg::IDX_W'(in_data.position);
        end
      end
      default: begin
        status = bal_pkg::ST_OK;
      end
    endcase
  end

  // row of cells
  for (genvar i = 0; i < bal_pkg::DEPTH; i++) begin : g_cell
    localparam logic [bal_pkg::CMP_W-1:0] IDX_C  = bal_pkg::CMP_W'(i);
    localparam logic [bal_pkg::CMP_W-1:0] IDX_C1 = bal_pkg::CMP_W'(i + 1);
    bal_pkg::cell_ctl_t ctl;
    bal_pkg::elem_t     prev_d;
    bal_pkg::elem_t     next_d;

    assign ctl.shift_up   = do_insert;
    assign ctl.shift_down = do_delete && (IDX_C >= pos_ext) && (IDX_C1 < cnt_ext);
    assign ctl.load       = do_append && (IDX_C == cnt_ext);

    if (i == 0) begin : g_first
      assign prev_d = new_elem;
    end else begin : g_mid_lo
      assign prev_d = cell_q[i-1];
    end
    if (i == bal_pkg::DEPTH - 1) begin : g_last
      assign next_d = cell_q[i];
    end else begin : g_mid_hi
      assign next_d = cell_q[i+1];
    end

    bal_cell u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .prev_d (prev_d),
      .next_d (next_d),
      .load_d (new_elem),
      .q      (cell_q[i])
    );
  end

  // result beat
  always_comb begin
    out_data_nxt.value_out = rd_en ? bal_pkg::VAL_W'(cell_q[rd_idx]) : '0;
    out_data_nxt.status    = status;
    out_data_nxt.count_out = bal_pkg::COUNT_W'(count_nxt);
    out_data_nxt.is_empty  = (count_nxt == '0);
    out_data_nxt.is_full   = (count_nxt == bal_pkg::CNT_W'(bal_pkg::DEPTH));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sv/bal_checker.sv]
// ----------------------------------------------------------------------------
// bal_checker - port-level checks for the bounded array list
// Watches request and result beats and the flags carried by each result.
// ----------------------------------------------------------------------------
module bal_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input bal_pkg::out_t out_data
);

  // every accepted request gives exactly one result beat, in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("missing result beat");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result beat without request");

  // flags agree with the count
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.is_empty == (out_data.count_out == '0)) &&
                   (out_data.is_full ==
                    (out_data.count_out == bal_pkg::COUNT_W'(bal_pkg::DEPTH)))))
    else $error("empty/full flags disagree with count");

  // failed requests return no data
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != bal_pkg::ST_OK)) |-> (out_data.value_out == '0))
    else $error("failed request returned data");

endmodule

bind bounded_array_list bal_checker u_bal_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

[bench/tb_bounded_array_list.sv]
// ----------------------------------------------------------------------------
// tb_bounded_array_list - self-checking bench for the bounded array list
// Drives a short table of directed requests, then random request streams.
// The random streams alternate between growing and shrinking the list so
// that it fills and drains many times. Every result beat is checked against
// the table's expectation in typed rows, else a behavioural copy of the list.
// Sender gaps vary by phase, and the sender drains the pipe between phases.
// ----------------------------------------------------------------------------
module tb_bounded_array_list;

  // request codes the block ignores
  localparam logic [bal_pkg::KIND_W-1:0] K_SPARE_LO  = 3'd5;
  localparam logic [bal_pkg::KIND_W-1:0] K_SPARE_MID = 3'd6;
  localparam logic [bal_pkg::KIND_W-1:0] K_SPARE_HI  = 3'd7;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 4;
  localparam int N_PLAN      = 25;
  localparam int N_PHASES    = 4;
  localparam int PHASE_ITEMS = 200;

  localparam bal_pkg::out_t UNTYPED = '0;

  // one row of the directed table; want is used only when typed is set
  typedef struct {
    bal_pkg::in_t  req;
    int            reps;
    bit            typed;
    bal_pkg::out_t want;
  } plan_row_t;

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  bal_pkg::in_t  in_data;
  logic          out_valid;
  bal_pkg::out_t out_data;

  // expectation that travels with the beat on the input side
  bit            drv_typed;
  bal_pkg::out_t drv_want;

  // behavioural copy of the list
  bal_pkg::elem_t list_cells [bal_pkg::DEPTH];
  int             list_len;

  bal_pkg::out_t results_due [$];
  bal_pkg::out_t pred_beat;
  bal_pkg::out_t due_beat;
  int            n_errors;
  int            n_cycles;

  plan_row_t plan [N_PLAN] = '{
    // empty list after reset
    '{bal_pkg::in_t'{bal_pkg::K_POP, 32'h0, 4'h0}, 1, 1'b1,
      bal_pkg::out_t'{32'h0, bal_pkg::ST_EMPTY, 5'd0, 1'b1, 1'b0}},
    '{bal_pkg::in_t'{bal_pkg::K_READ, 32'h0, 4'h0}, 1, 1'b1,
      bal_pkg::out_t'{32'h0, bal_pkg::ST_EMPTY, 5'd0, 1'b1, 1'b0}},
    '{bal_pkg::in_t'{bal_pkg::K_DELETE, 32'h0, 4'hf}, 1, 1'b1,
      bal_pkg::out_t'{32'h0, bal_pkg::ST_EMPTY, 5'd0, 1'b1, 1'b0}},
    '{bal_pkg::in_t'{K_SPARE_HI, 32'hffff_ffff, 4'hf}, 1, 1'b1,
      bal_pkg::out_t'{32'h0, bal_pkg::ST_OK, 5'd0, 1'b1, 1'b0}},
    // value extremes at both ends
    '{bal_pkg::in_t'{bal_pkg::K_APPEND, 32'hffff_ffff, 4'hf}, 1, 1'b1,
      bal_pkg::out_t'{32'h0, bal_pkg::ST_OK, 5'd1, 1'b0, 1'b0}},
    '{bal_pkg::in_t'{bal_pkg::K_INSERT, 32'h0, 4'h0}, 1, 1'b1,
      bal_pkg::out_t'{32'h0, bal_pkg::ST_OK, 5'd2, 1'b0, 1'b0}},
    '{bal_pkg::in_t'{bal_pkg::K_READ, 32'h0, 4'h0}, 1, 1'b1,
      bal_pkg::out_t'{32'h0, bal_pkg::ST_OK, 5'd2, 1'b0, 1'b0}},
    '{bal_pkg::in_t'{bal_pkg::K_READ, 32'h0, 4'h1}, 1, 1'b1,
      bal_pkg::out_t'{32'hffff_ffff, bal_pkg::ST_OK, 5'd2, 1'b0, 1'b0}},
    // positions past the end
    '{bal_pkg::in_t'{bal_pkg::K_READ, 32'h0, 4'hf}, 1, 1'b1,
      bal_pkg::out_t'{32'h0, bal_pkg::ST_BADPOS, 5'd2, 1'b0, 1'b0}},
    '{bal_pkg::in_t'{bal_pkg::K_DELETE, 32'h0, 4'h2}, 1, 1'b1,
      bal_pkg::out_t'{32'h0, bal_pkg::ST_BADPOS, 5'd2, 1'b0, 1'b0}},
    // fill to the top
    '{bal_pkg::in_t'{bal_pkg::K_APPEND, 32'h1234_5678, 4'h0}, 14, 1'b0, UNTYPED},
    '{bal_pkg::in_t'{bal_pkg::K_APPEND, 32'h5555_aaaa, 4'h0}, 1, 1'b1,
      bal_pkg::out_t'{32'h0, bal_pkg::ST_FULL, 5'd16, 1'b0, 1'b1}},
    '{bal_pkg::in_t'{bal_pkg::K_INSERT, 32'haaaa_5555, 4'h0}, 1, 1'b1,
      bal_pkg::out_t'{32'h0, bal_pkg::ST_FULL, 5'd16, 1'b0, 1'b1}},
    '{bal_pkg::in_t'{bal_pkg::K_READ, 32'h0, 4'hf}, 1, 1'b0, UNTYPED},
    '{bal_pkg::in_t'{bal_pkg::K_DELETE, 32'h0, 4'h0}, 1, 1'b0, UNTYPED},
    '{bal_pkg::in_t'{bal_pkg::K_INSERT, 32'h8000_0001, 4'h0}, 1, 1'b0, UNTYPED},
    '{bal_pkg::in_t'{bal_pkg::K_READ, 32'h0, 4'h0}, 1, 1'b0, UNTYPED},
    '{bal_pkg::in_t'{bal_pkg::K_POP, 32'h0, 4'h0}, 1, 1'b0, UNTYPED},
    '{bal_pkg::in_t'{bal_pkg::K_DELETE, 32'h0, 4'hf}, 1, 1'b1,
      bal_pkg::out_t'{32'h0, bal_pkg::ST_BADPOS, 5'd15, 1'b0, 1'b0}},
    '{bal_pkg::in_t'{K_SPARE_LO, 32'h0, 4'h3}, 1, 1'b0, UNTYPED},
    '{bal_pkg::in_t'{K_SPARE_MID, 32'h0, 4'h7}, 1, 1'b0, UNTYPED},
    '{bal_pkg::in_t'{bal_pkg::K_DELETE, 32'h0, 4'h7}, 1, 1'b0, UNTYPED},
    // drain to empty
    '{bal_pkg::in_t'{bal_pkg::K_POP, 32'h0, 4'h0}, 14, 1'b0, UNTYPED},
    '{bal_pkg::in_t'{bal_pkg::K_POP, 32'h0, 4'h0}, 1, 1'b1,
      bal_pkg::out_t'{32'h0, bal_pkg::ST_EMPTY, 5'd0, 1'b1, 1'b0}},
    '{bal_pkg::in_t'{bal_pkg::K_INSERT, 32'hdead_beef, 4'h0}, 1, 1'b0, UNTYPED}
  };

  bounded_array_list u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  // apply one request to the list copy and return its result beat
  function automatic bal_pkg::out_t list_apply(bal_pkg::in_t req);
    bal_pkg::out_t  res;
    bal_pkg::elem_t fetched;
    int             i;
    int             pos;
    res     = '0;
    fetched = '0;
    pos     = int'(req.position);
    res.status = bal_pkg::ST_OK;
    case (req.kind)
      bal_pkg::K_APPEND: begin
        if (list_len >= bal_pkg::DEPTH) begin
          res.status = bal_pkg::ST_FULL;
        end else begin
          list_cells[list_len] = bal_pkg::elem_t'(req.value_in);
          list_len++;
        end
      end
      bal_pkg::K_INSERT: begin
        if (list_len >= bal_pkg::DEPTH) begin
          res.status = bal_pkg::ST_FULL;
        end else begin
          for (i = list_len; i > 0; i--) list_cells[i] = list_cells[i-1];
          list_cells[0] = bal_pkg::elem_t'(req.value_in);
          list_len++;
        end
      end
      bal_pkg::K_DELETE: begin
        if (list_len == 0) begin
          res.status = bal_pkg::ST_EMPTY;
        end else if (pos >= list_len) begin
          res.status = bal_pkg::ST_BADPOS;
        end else begin
          for (i = pos; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
          list_len--;
        end
      end
      bal_pkg::K_POP: begin
        if (list_len == 0) begin
          res.status = bal_pkg::ST_EMPTY;
        end else begin
          list_len--;
          fetched = list_cells[list_len];
        end
      end
      bal_pkg::K_READ: begin
        if (list_len == 0) begin
          res.status = bal_pkg::ST_EMPTY;
        end else if (pos >= list_len) begin
          res.status = bal_pkg::ST_BADPOS;
        end else begin
          fetched = list_cells[pos];
        end
      end
      default: ;
    endcase
    res.value_out = bal_pkg::VAL_W'(fetched);
    res.count_out = bal_pkg::COUNT_W'(list_len);
    res.is_empty  = (list_len == 0);
    res.is_full   = (list_len == bal_pkg::DEPTH);
    return res;
  endfunction

  // random request, biased towards filling or draining the list
  function automatic bal_pkg::in_t rand_request(bit growing);
    bal_pkg::in_t req;
    int           pick;
    pick = $urandom_range(99);
    req.value_in = $urandom();
    case ($urandom_range(7))
      0: req.value_in = '0;
      1: req.value_in = '1;
      default: ;
    endcase
    req.position = $urandom_range(1) ? bal_pkg::POS_W'($urandom_range(15))
                                     : bal_pkg::POS_W'($urandom_range(3));
    if (pick < 3)
      req.kind = bal_pkg::KIND_W'($urandom_range(int'(K_SPARE_HI), int'(K_SPARE_LO)));
    else if (growing)
      req.kind = (pick < 38) ? bal_pkg::K_APPEND : (pick < 60) ? bal_pkg::K_INSERT :
                 (pick < 70) ? bal_pkg::K_DELETE : (pick < 78) ? bal_pkg::K_POP :
                 bal_pkg::K_READ;
    else
      req.kind = (pick < 13) ? bal_pkg::K_APPEND : (pick < 23) ? bal_pkg::K_INSERT :
                 (pick < 50) ? bal_pkg::K_DELETE : (pick < 72) ? bal_pkg::K_POP :
                 bal_pkg::K_READ;
    return req;
  endfunction

  // present one beat and hold it until the block takes it
  task automatic send(input bal_pkg::in_t req, input bit typed, input bal_pkg::out_t want);
    start     <= 1'b1;
    in_data   <= req;
    drv_typed <= typed;
    drv_want  <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // idle the sender at random; pct is the odds, in percent, of going on idling
  task automatic sender_gap(input int pct);
    while ($urandom_range(99) < pct) begin
      start   <= 1'b0;
      in_data <= bal_pkg::in_t'{bal_pkg::KIND_W'($urandom()), $urandom(),
                                bal_pkg::POS_W'($urandom())};
      @(posedge clk);
    end
  endtask

  // hold off until every outstanding result has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // predict on every accepted beat, check every result beat
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        pred_beat = list_apply(in_data);
        results_due.push_back(drv_typed ? drv_want : pred_beat);
      end
      if (out_valid) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result beat value=%h status=%0d count=%0d empty=%b full=%b",
                   $time, out_data.value_out, out_data.status, out_data.count_out,
                   out_data.is_empty, out_data.is_full);
          n_errors++;
        end else begin
          due_beat = results_due.pop_front();
          if (out_data.value_out !== due_beat.value_out ||
              out_data.status    !== due_beat.status    ||
              out_data.count_out !== due_beat.count_out ||
              out_data.is_empty  !== due_beat.is_empty  ||
              out_data.is_full   !== due_beat.is_full) begin
            $display("%0t: mismatch expected value=%h status=%0d count=%0d empty=%b full=%b",
                     $time, due_beat.value_out, due_beat.status, due_beat.count_out,
                     due_beat.is_empty, due_beat.is_full);
            $display("%0t:          actual   value=%h status=%0d count=%0d empty=%b full=%b",
                     $time, out_data.value_out, out_data.status, out_data.count_out,
                     out_data.is_empty, out_data.is_full);
            n_errors++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("bounded_array_list regression: fail");
      $finish;
    end
  end

  int phase_idle [N_PHASES] = '{0, 82, 15, 0};

  initial begin
    int  n;
    int  ph;
    int  run_left;
    bit  growing;
    clk       = 1'b0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    drv_typed = 1'b0;
    drv_want  = '0;
    list_len  = 0;
    n_errors  = 0;
    n_cycles  = 0;
    growing   = 1'b1;
    run_left  = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed table, back to back
    foreach (plan[r]) begin
      for (n = 0; n < plan[r].reps; n++) begin
        send(bal_pkg::in_t'{plan[r].req.kind, plan[r].req.value_in + 32'(n),
                            plan[r].req.position},
             plan[r].typed, plan[r].want);
      end
    end
    drain();

    // random phases with different sender idling, drained in between
    for (ph = 0; ph < N_PHASES; ph++) begin
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (run_left == 0) begin
          growing  = !growing;
          run_left = $urandom_range(50, 15);
        end
        run_left--;
        sender_gap(phase_idle[ph]);
        send(rand_request(growing), 1'b0, UNTYPED);
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_errors == 0 && results_due.size() == 0) begin
      $display("bounded_array_list regression: pass");
    end else begin
      $display("bounded_array_list regression: fail");
    end
    $finish;
  end

endmodule
